@@ rtl/core/lpff_pkg.sv @@
// Shared constants, codes and types of the length-prefixed frame FIFO.
package lpff_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int SIZE_RST  = 1024;
    localparam int SIZE_MIN  = 4;

    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;
    localparam int CFG_SIZEW = 11;

    localparam logic REG_SIZE = 1'b0;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_BEGIN = 2'd0;
    localparam t_kind KIND_DATA  = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NO_SPACE = 3'd1;
    localparam t_status ST_STRAY    = 3'd2;
    localparam t_status ST_BUSY     = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;
    localparam t_status ST_BAD_LEN  = 3'd5;
    localparam t_status ST_UNDERRUN = 3'd6;

    typedef logic [7:0] t_byte;
    typedef logic [9:0] t_fill;

    typedef struct packed {
        t_status status;
        t_byte   data_out;
        t_byte   frame_length;
        logic    last;
        t_fill   fill_level;
    } t_result;

endpackage

@@ rtl/core/lpff_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface lpff_in_if;
    logic                valid;
    logic                ready;
    lpff_pkg::t_kind     kind;
    lpff_pkg::t_byte     new_frame_length;
    lpff_pkg::t_byte     data_in;

    modport source (output valid, output kind, output new_frame_length, output data_in,
                    input ready);
    modport sink   (input valid, input kind, input new_frame_length, input data_in,
                    output ready);
endinterface

interface lpff_out_if;
    logic                valid;
    logic                ready;
    lpff_pkg::t_status   status;
    lpff_pkg::t_byte     data_out;
    lpff_pkg::t_byte     frame_length;
    logic                last;
    lpff_pkg::t_fill     fill_level;

    modport source (output valid, output status, output data_out, output frame_length,
                    output last, output fill_level, input ready);
    modport sink   (input valid, input status, input data_out, input frame_length,
                    input last, input fill_level, output ready);
endinterface

@@ rtl/core/lpff_cfg.sv @@
// APB-style register port holding the clamped ring size.
module lpff_cfg #(
    parameter  int DEPTH = lpff_pkg::DEPTH_DEF,
    localparam int SW    = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpff_pkg::CFG_AW-1:0]   paddr,
    input  logic [lpff_pkg::CFG_DW-1:0]   pwdata,
    output logic [lpff_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output logic [SW-1:0]                 o_size,
    output logic                          o_wr
);

    localparam int SIZE_RST_C = (DEPTH < lpff_pkg::SIZE_RST) ? DEPTH : lpff_pkg::SIZE_RST;

    logic [SW-1:0]                  r_size;
    logic [SW-1:0]                  n_size;
    logic [lpff_pkg::CFG_SIZEW-1:0] w_val;
    logic                           w_hit;

    assign w_val  = pwdata[lpff_pkg::CFG_SIZEW-1:0];
    assign w_hit  = (paddr[lpff_pkg::CFG_AW-1:2] == lpff_pkg::REG_SIZE);
    assign o_wr   = psel && penable && pwrite && w_hit;
    assign pready = 1'b1;
    assign o_size = r_size;
    assign prdata = w_hit ? lpff_pkg::CFG_DW'(r_size) : '0;

    always_comb begin
        priority if (w_val < lpff_pkg::CFG_SIZEW'(lpff_pkg::SIZE_MIN)) begin
            n_size = SW'(lpff_pkg::SIZE_MIN);
        end else if (32'(w_val) > 32'(DEPTH)) begin
            n_size = SW'(DEPTH);
        end else begin
            n_size = SW'(w_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SW'(SIZE_RST_C);
        end else if (o_wr) begin
            r_size <= n_size;
        end
    end

endmodule

@@ rtl/core/lpff_ctrl.sv @@
// Ring storage, frame sequencer and result register.
module lpff_ctrl #(
    parameter  int DEPTH = lpff_pkg::DEPTH_DEF,
    localparam int SW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr,
    input  logic [SW-1:0] i_size,
    lpff_in_if.sink       i_item,
    lpff_out_if.source    o_result
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = ((SW > 8) ? SW : 8) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [SW-1:0] sz);
        logic [SW:0] q;
        q = {1'b0, SW'(p)} + (SW + 1)'(1);
        if (q >= {1'b0, sz}) begin
            return '0;
        end
        return PW'(q);
    endfunction

    function automatic logic [SW-1:0] fill_of(input logic [PW-1:0] wp, input logic [PW-1:0] rp,
                                              input logic [SW-1:0] sz);
        if (wp >= rp) begin
            return SW'(wp) - SW'(rp);
        end
        return sz - (SW'(rp) - SW'(wp));
    endfunction

    logic [7:0]            r_mem [DEPTH];
    lpff_pkg::t_byte       r_rdata;

    logic [1:0]            r_state, n_state;
    logic [PW-1:0]         r_wp, n_wp;
    logic [PW-1:0]         r_rp, n_rp;
    lpff_pkg::t_byte       r_wl, n_wl;
    logic                  r_writing, n_writing;
    lpff_pkg::t_byte       r_rl, n_rl;
    logic                  r_reading, n_reading;
    lpff_pkg::t_byte       r_cur, n_cur;

    lpff_pkg::t_kind       r_kind;
    lpff_pkg::t_byte       r_nlen;
    lpff_pkg::t_byte       r_din;

    logic                  r_ovalid;
    lpff_pkg::t_result     r_out;
    lpff_pkg::t_result     w_res;
    logic                  w_load;

    logic                  w_we, w_re;
    logic [PW-1:0]         w_waddr, w_raddr;
    lpff_pkg::t_byte       w_wdata;

    logic [SW-1:0]         w_fill;
    logic [SW-1:0]         w_free;
    logic [SW-1:0]         w_nfill;
    logic [31:0]           w_nfill_ext;
    logic                  w_out_free;
    logic                  w_accept;
    logic [PW-1:0]         w_rp_next;
    lpff_pkg::t_byte       w_rl_dec;

    assign w_fill      = fill_of(r_wp, r_rp, i_size);
    assign w_free      = i_size - w_fill - SW'(1);
    assign w_out_free  = !r_ovalid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept    = i_item.valid && i_item.ready;
    assign w_rp_next   = adv(r_rp, i_size);
    assign w_rl_dec    = r_rl - 8'd1;
    assign w_nfill     = fill_of(n_wp, n_rp, i_size);
    assign w_nfill_ext = 32'(w_nfill);

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_wl      = r_wl;
        n_writing = r_writing;
        n_rl      = r_rl;
        n_reading = r_reading;
        n_cur     = r_cur;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_waddr   = r_wp;
        w_raddr   = r_rp;
        w_wdata   = r_din;
        w_load    = 1'b0;
        w_res     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                    w_re    = 1'b1;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    w_load  = 1'b1;
                    unique case (r_kind)
                        lpff_pkg::KIND_BEGIN: begin
                            if (r_writing) begin
                                w_res.status = lpff_pkg::ST_BUSY;
                            end else if (CW'(w_free) >= CW'(r_nlen) + CW'(1)) begin
                                w_we      = 1'b1;
                                w_wdata   = r_nlen;
                                n_wp      = adv(r_wp, i_size);
                                n_wl      = r_nlen;
                                n_writing = (r_nlen != 8'd0);
                            end else begin
                                w_res.status = lpff_pkg::ST_NO_SPACE;
                            end
                        end
                        lpff_pkg::KIND_DATA: begin
                            if (!r_writing) begin
                                w_res.status = lpff_pkg::ST_STRAY;
                            end else if (w_fill >= i_size - SW'(1)) begin
                                w_res.status = lpff_pkg::ST_NO_SPACE;
                            end else begin
                                w_we    = 1'b1;
                                w_wdata = r_din;
                                n_wp    = adv(r_wp, i_size);
                                n_wl    = r_wl - 8'd1;
                                if (r_wl == 8'd1) begin
                                    n_writing = 1'b0;
                                end
                            end
                        end
                        lpff_pkg::KIND_READ: begin
                            if (!r_reading) begin
                                if (w_fill == '0) begin
                                    w_res.status = lpff_pkg::ST_EMPTY;
                                end else begin
                                    w_res.frame_length = r_rdata;
                                    if (r_rdata == 8'd0 || CW'(r_rdata) > CW'(w_fill)) begin
                                        n_rp         = r_wp;
                                        n_wl         = '0;
                                        n_writing    = 1'b0;
                                        w_res.status = lpff_pkg::ST_BAD_LEN;
                                    end else begin
                                        n_cur     = r_rdata;
                                        n_rl      = r_rdata;
                                        n_reading = 1'b1;
                                        n_rp      = w_rp_next;
                                        if (w_fill == SW'(1)) begin
                                            w_res.status = lpff_pkg::ST_UNDERRUN;
                                        end else begin
                                            w_re    = 1'b1;
                                            w_raddr = w_rp_next;
                                            w_load  = 1'b0;
                                            n_state = S_DATA;
                                        end
                                    end
                                end
                            end else begin
                                w_res.frame_length = r_cur;
                                if (w_fill == '0) begin
                                    w_res.status = lpff_pkg::ST_UNDERRUN;
                                end else begin
                                    w_res.data_out = r_rdata;
                                    n_rp           = w_rp_next;
                                    n_rl           = w_rl_dec;
                                    if (w_rl_dec == 8'd0) begin
                                        n_reading  = 1'b0;
                                        w_res.last = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                            w_res.status = lpff_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DATA: begin
                if (w_out_free) begin
                    n_state            = S_IDLE;
                    w_load             = 1'b1;
                    w_res.frame_length = r_cur;
                    w_res.data_out     = r_rdata;
                    n_rp               = w_rp_next;
                    n_rl               = w_rl_dec;
                    if (w_rl_dec == 8'd0) begin
                        n_reading  = 1'b0;
                        w_res.last = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_res.fill_level = w_nfill_ext[9:0];
    end

    // one access per cycle; the sequencer never reads an entry in the cycle it is written
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_item.kind;
            r_nlen <= i_item.new_frame_length;
            r_din  <= i_item.data_in;
        end
        if (w_load) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_wl      <= '0;
            r_writing <= 1'b0;
            r_rl      <= '0;
            r_reading <= 1'b0;
            r_cur     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr) begin
                r_wp      <= '0;
                r_rp      <= '0;
                r_wl      <= '0;
                r_writing <= 1'b0;
                r_rl      <= '0;
                r_reading <= 1'b0;
                r_cur     <= '0;
            end else begin
                r_wp      <= n_wp;
                r_rp      <= n_rp;
                r_wl      <= n_wl;
                r_writing <= n_writing;
                r_rl      <= n_rl;
                r_reading <= n_reading;
                r_cur     <= n_cur;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_ovalid;
    assign o_result.status       = r_out.status;
    assign o_result.data_out     = r_out.data_out;
    assign o_result.frame_length = r_out.frame_length;
    assign o_result.last         = r_out.last;
    assign o_result.fill_level   = r_out.fill_level;

endmodule

@@ rtl/core/length_prefixed_frame_fifo.sv @@
// Top level of the length-prefixed frame ring FIFO.
//
//   channel    dir   handshake                     payload
//   i_item     in    valid/ready                   kind, new_frame_length, data_in
//   o_result   out   valid/ready                   status, data_out, frame_length, last,
//                                                  fill_level
//   cfg        in    psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// Writes, kind 3, continued reads and frame-start reads that end empty, flushed or in
// underrun go through accept, then one memory access. A frame-start read that returns
// data goes through its length byte, then its first data byte, both through the single-port
// ring memory. One result register; a new item is taken while it waits.
// Synchronous active-low reset empties the ring; no clearing pass. Output stall holds the
// sequencer in its execute and data states, also in the step that reads the first data byte.
module length_prefixed_frame_fifo #(
    parameter int DEPTH = lpff_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lpff_in_if.sink                       i_item,
    lpff_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lpff_pkg::CFG_AW-1:0]   paddr,
    input  logic [lpff_pkg::CFG_DW-1:0]   pwdata,
    output logic [lpff_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int SW = $clog2(DEPTH + 1);

    logic [SW-1:0] w_size;
    logic          w_cfg_wr;

    lpff_cfg #(.DEPTH(DEPTH)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_size  (w_size),
        .o_wr    (w_cfg_wr)
    );

    lpff_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (w_cfg_wr),
        .i_size   (w_size),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

@@ rtl/core/lpff_check.sv @@
// Port-level assertions for the frame FIFO, bound to the top level.
module lpff_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input lpff_pkg::t_status   i_out_status,
    input lpff_pkg::t_byte     i_out_data,
    input logic                i_out_last,
    input lpff_pkg::t_fill     i_out_fill
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_data) && $stable(i_out_fill))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transaction accepted during execution");

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_status == lpff_pkg::ST_OK)
        else $error("last flagged on a failed read");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != lpff_pkg::ST_OK |-> i_out_data == '0)
        else $error("data on a failed transaction");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == lpff_pkg::ST_EMPTY
            || i_out_status == lpff_pkg::ST_BAD_LEN) |-> i_out_fill == '0)
        else $error("ring not empty after empty or flush");

endmodule

bind length_prefixed_frame_fifo lpff_check u_lpff_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_status (o_result.status),
    .i_out_data   (o_result.data_out),
    .i_out_last   (o_result.last),
    .i_out_fill   (o_result.fill_level)
);

@@ tb/frame_fifo_checker.sv @@
// Checker for the frame FIFO: tracks size writes, predicts each result and compares it.
module frame_fifo_checker
    import lpff_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    lpff_in_if                i_item,
    lpff_out_if               i_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    input  logic              pready,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam logic [CFG_AW-1:0] SIZE_ADDR = {REG_SIZE, 2'b00};

    t_byte       ring_mem [RING_DEPTH];
    int unsigned ring_size = SIZE_RST;
    int unsigned head = 0;
    int unsigned tail = 0;
    int unsigned write_left = 0;
    int unsigned read_left = 0;
    bit          write_open = 1'b0;
    bit          read_open = 1'b0;
    t_byte       read_len = '0;
    t_result     expected_q [$];

    int fail_total = 0;
    int pending_total = 0;
    int checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;

    function automatic int unsigned clamp_size(logic [CFG_SIZEW-1:0] raw);
        if (raw < SIZE_MIN) return SIZE_MIN;
        if (raw > RING_DEPTH) return RING_DEPTH;
        return raw;
    endfunction

    function automatic int unsigned stored_count();
        return (tail >= head) ? tail - head : ring_size - (head - tail);
    endfunction

    function automatic int unsigned next_slot(int unsigned p);
        return (p + 1 >= ring_size) ? 0 : p + 1;
    endfunction

    function automatic void clear_ring();
        head        = 0;
        tail        = 0;
        write_left  = 0;
        write_open  = 1'b0;
        read_left   = 0;
        read_open   = 1'b0;
        read_len    = '0;
    endfunction

    function automatic void put_byte(t_byte b);
        ring_mem[tail] = b;
        tail = next_slot(tail);
    endfunction

    function automatic t_byte take_byte();
        t_byte b;
        b = ring_mem[head];
        head = next_slot(head);
        return b;
    endfunction

    function automatic t_result predict_result(t_kind kind, t_byte nlen, t_byte din);
        t_result     r;
        int unsigned fill;
        t_byte       len;
        r = '0;
        fill = stored_count();
        case (kind)
            KIND_BEGIN: begin
                if (write_open) begin
                    r.status = ST_BUSY;
                end else if (ring_size - fill - 1 >= nlen + 1) begin
                    put_byte(nlen);
                    write_left = nlen;
                    write_open = (nlen != 0);
                end else begin
                    r.status = ST_NO_SPACE;
                end
            end
            KIND_DATA: begin
                if (!write_open) begin
                    r.status = ST_STRAY;
                end else if (fill >= ring_size - 1) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    put_byte(din);
                    write_left--;
                    if (write_left == 0) write_open = 1'b0;
                end
            end
            KIND_READ: begin
                if (!read_open) begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        len = take_byte();
                        r.frame_length = len;
                        if (len == 0 || len > fill) begin
                            // bad length byte: drop everything, cancel any open write
                            head       = tail;
                            write_left = 0;
                            write_open = 1'b0;
                            r.status   = ST_BAD_LEN;
                        end else begin
                            read_len  = len;
                            read_left = len;
                            read_open = 1'b1;
                            if (fill == 1) begin
                                r.status = ST_UNDERRUN;
                            end else begin
                                r.data_out = take_byte();
                                read_left--;
                                if (read_left == 0) begin
                                    read_open = 1'b0;
                                    r.last    = 1'b1;
                                end
                            end
                        end
                    end
                end else begin
                    r.frame_length = read_len;
                    if (fill == 0) begin
                        r.status = ST_UNDERRUN;
                    end else begin
                        r.data_out = take_byte();
                        read_left--;
                        if (read_left == 0) begin
                            read_open = 1'b0;
                            r.last    = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.fill_level = t_fill'(stored_count());
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at result %0d: %s", checked_total, msg);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            ring_size = clamp_size(CFG_SIZEW'(SIZE_RST));
            clear_ring();
            expected_q.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.status       = i_result.status;
                got.data_out     = i_result.data_out;
                got.frame_length = i_result.frame_length;
                got.last         = i_result.last;
                got.fill_level   = i_result.fill_level;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, status %0d",
                                              got.status));
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.data_out !== want.data_out)
                        report_mismatch($sformatf("data_out %0h, expected %0h",
                                                  got.data_out, want.data_out));
                    if (got.frame_length !== want.frame_length)
                        report_mismatch($sformatf("frame_length %0d, expected %0d",
                                                  got.frame_length, want.frame_length));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  got.last, want.last));
                    if (got.fill_level !== want.fill_level)
                        report_mismatch($sformatf("fill_level %0d, expected %0d",
                                                  got.fill_level, want.fill_level));
                    checked_total++;
                end
            end
            if (i_item.valid && i_item.ready) begin
                expected_q.push_back(predict_result(i_item.kind, i_item.new_frame_length,
                                                    i_item.data_in));
            end
            if (psel && penable && pwrite && pready && paddr == SIZE_ADDR) begin
                ring_size = clamp_size(pwdata[CFG_SIZEW-1:0]);
                clear_ring();
            end
        end
        pending_total = expected_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// Testbench top: drives frame traffic and size writes into the frame FIFO, gives the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lpff_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 37;
    localparam int NOISE_PCT     = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_SEG       = 10;
    localparam int ITEMS_PER_SEG = 190;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int SEG_SMALL     = 1;
    localparam int SEG_PAUSE     = 2;
    localparam int SEG_NO_IDLE   = 3;
    localparam int SEG_HOLD      = 6;
    localparam t_kind KIND_NONE  = 2'd3;
    localparam logic [CFG_AW-1:0] SIZE_ADDR = {REG_SIZE, 2'b00};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    lpff_in_if  item_ch ();
    lpff_out_if result_ch ();

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent = 0;
    int size_writes = 0;
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;

    // rough view of ring occupancy, only used to shape the traffic
    int ring_cap = SIZE_RST;
    int stored_bytes = 0;
    int wr_left = 0;
    int rd_left = 0;
    bit rd_active = 1'b0;
    int frame_q [$];

    logic [CFG_DW-1:0] size_plan [NUM_SEG];

    length_prefixed_frame_fifo u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    frame_fifo_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                result_ch.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
                hold_request = 1'b0;
            end
            result_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(t_kind kind, t_byte nlen, t_byte din);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.kind             <= kind;
        item_ch.new_frame_length <= nlen;
        item_ch.data_in          <= din;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic issue_begin(int len);
        if (wr_left == 0 && ring_cap - stored_bytes - 1 >= len + 1) begin
            stored_bytes++;
            frame_q.push_back(len);
            wr_left = len;
        end
        send_item(KIND_BEGIN, t_byte'(len), t_byte'($urandom));
    endtask

    task automatic issue_data(t_byte b);
        if (wr_left > 0) begin
            stored_bytes++;
            wr_left--;
        end
        send_item(KIND_DATA, t_byte'($urandom), b);
    endtask

    task automatic issue_read();
        if (rd_active) begin
            if (stored_bytes > 0) begin
                stored_bytes--;
                rd_left--;
            end
        end else if (frame_q.size() > 0) begin
            if (frame_q[0] == 0 || frame_q[0] > stored_bytes) begin
                stored_bytes = 0;
                wr_left = 0;
                frame_q.delete();
            end else begin
                stored_bytes--;
                rd_active = 1'b1;
                rd_left = frame_q[0];
                if (stored_bytes > 0) begin
                    stored_bytes--;
                    rd_left--;
                end
            end
        end
        if (rd_active && rd_left == 0) begin
            rd_active = 1'b0;
            void'(frame_q.pop_front());
        end
        send_item(KIND_READ, t_byte'($urandom), t_byte'($urandom));
    endtask

    function automatic bit frame_readable();
        return rd_active ||
               (frame_q.size() > 0 && frame_q[0] != 0 && frame_q[0] <= stored_bytes);
    endfunction

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_size(logic [CFG_DW-1:0] value);
        logic [CFG_SIZEW-1:0] raw;
        raw = value[CFG_SIZEW-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (raw < SIZE_MIN) ring_cap = SIZE_MIN;
        else if (raw > DEPTH_DEF) ring_cap = DEPTH_DEF;
        else ring_cap = raw;
        stored_bytes = 0;
        wr_left = 0;
        rd_left = 0;
        rd_active = 1'b0;
        frame_q.delete();
        size_writes++;
    endtask

    initial begin
        int seg;
        int n;
        int r;
        int free_bytes;
        int len;
        size_plan = '{32'(SIZE_RST), 32'd0, 32'd7, 32'd2047, 32'd64, 32'd4,
                      32'd1000, 32'd1024, 32'hFFFF_F818, 32'd33};
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        item_ch.valid            = 1'b0;
        item_ch.kind             = KIND_NONE;
        item_ch.new_frame_length = '0;
        item_ch.data_in          = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corner cases at the reset size
        issue_read();
        issue_data(8'hFF);
        send_item(KIND_NONE, 8'hFF, 8'hFF);
        issue_begin(0);
        issue_read();
        issue_begin(3);
        issue_begin(5);
        issue_data(8'h00);
        issue_read();
        issue_data(8'h80);
        issue_begin(1);
        issue_read();
        issue_data(8'hA5);
        issue_read();
        issue_read();
        issue_begin(255);
        issue_read();
        issue_begin(2);
        issue_data(8'h5A);
        issue_data(8'hC3);
        issue_read();
        issue_read();

        for (seg = 0; seg < NUM_SEG; seg++) begin
            if (seg > 0) begin
                wait_drained();
                write_size(size_plan[seg]);
            end
            no_idle = (seg == SEG_NO_IDLE);
            if (seg == SEG_HOLD) hold_request = 1'b1;
            if (seg == SEG_SMALL) begin
                // smallest ring: oversized frame, exact fit, then full
                issue_begin(3);
                issue_begin(2);
                issue_data(8'h0F);
                issue_data(8'hF0);
                issue_begin(0);
            end
            for (n = 0; n < ITEMS_PER_SEG; n++) begin
                if (seg == SEG_PAUSE && n == ITEMS_PER_SEG / 2) wait_drained();
                r = $urandom_range(0, 99);
                free_bytes = ring_cap - stored_bytes - 1;
                if (r < NOISE_PCT) begin
                    case ($urandom_range(0, 4))
                        0: send_item(KIND_NONE, t_byte'($urandom), t_byte'($urandom));
                        1: issue_data(t_byte'($urandom));
                        2: issue_begin($urandom_range(0, 255));
                        3: issue_begin(0);
                        default: issue_read();
                    endcase
                end else if (wr_left > 0 && (r < 62 || !frame_readable())) begin
                    issue_data(t_byte'($urandom));
                end else if (frame_readable() && (r < 55 || wr_left > 0 || free_bytes < 2)) begin
                    issue_read();
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 70) len = $urandom_range(1, 8);
                    else if (r < 92) len = $urandom_range(9, 40);
                    else len = $urandom_range(41, 255);
                    if (free_bytes >= 2 && len > free_bytes - 1)
                        len = $urandom_range(1, free_bytes - 1);
                    issue_begin(len);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d transactions and checked %0d results over %0d ring sizes",
                 items_sent, checked, size_writes + 1);
        $display("Traffic had 0..255 byte frames, flushes, underruns, full rings, %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lpff_pkg.sv
rtl/core/lpff_if.sv
rtl/core/lpff_cfg.sv
rtl/core/lpff_ctrl.sv
rtl/core/length_prefixed_frame_fifo.sv
rtl/core/lpff_check.sv
tb/frame_fifo_checker.sv
tb/testbench.sv
